FILE: rtl/core/ccps_pkg.sv
`timescale 1ns / 1ps

package ccps_pkg;

	localparam int unsigned ChanW = 8;
	localparam int unsigned CfgDataW = 40;
	localparam int unsigned CfgIdxW = 3;
	localparam logic [ChanW-1:0] FullLevel = 8'hFF;
	localparam logic [ChanW-1:0] ZeroLevel = 8'h00;

	typedef enum logic [CfgIdxW-1:0] {
		REG_ORANGE_WINDOW  = 3'd0,
		REG_YELLOW_WINDOW  = 3'd1,
		REG_GREEN_DIFF     = 3'd2,
		REG_BLUE_DIFF      = 3'd3,
		REG_WHITE_BLACK    = 3'd4,
		REG_LABEL_HUES     = 3'd5,
		REG_TILT_RULE      = 3'd6,
		REG_FRAME_SETTINGS = 3'd7
	} reg_idx_t;

	typedef struct packed {
		logic [ChanW-1:0] red_in;
		logic [ChanW-1:0] green_in;
		logic [ChanW-1:0] blue_in;
		logic [ChanW-1:0] hue_in;
		logic [ChanW-1:0] sat_in;
		logic [ChanW-1:0] val_in;
	} pix_in_t;

	typedef struct packed {
		logic [ChanW-1:0] hue_out;
		logic [ChanW-1:0] sat_out;
		logic [ChanW-1:0] val_out;
	} pix_out_t;

	// Hue/sat/value window: fields listed MSB first to match the packed layout.
	typedef struct packed {
		logic [ChanW-1:0] min_val;
		logic [ChanW-1:0] min_sat;
		logic [ChanW-1:0] max_hue;
		logic [ChanW-1:0] min_hue;
	} window_t;

	typedef struct packed {
		window_t      orange_window;
		window_t      yellow_window;
		logic [31:0]  green_diff_limits;
		logic [31:0]  blue_diff_limits;
		logic [23:0]  white_black_limits;
		logic [39:0]  label_hues;
		logic [31:0]  tilt_rule;
		logic [16:0]  frame_settings;
	} cfg_t;

endpackage

FILE: rtl/core/ccps_classify.sv
`timescale 1ns / 1ps

module ccps_classify
	import ccps_pkg::*;
(
	input  cfg_t     cfg,
	input  pix_in_t  pix,
	output pix_out_t res
);

	// 18-bit signed covers channel differences and threshold minus offset
	typedef logic signed [17:0] wide_t;

	logic [ChanW-1:0] r_sw, b_sw;
	logic [ChanW-1:0] blue_hue, green_hue, orange_hue, yellow_hue, misc_hue;
	logic [ChanW-1:0] wht_max_sat, wht_min_val, blk_max_val;
	wide_t            d_br, d_bg, d_gr, d_gb;
	wide_t            thr_br, thr_bg, thr_gr, thr_gb, offset;
	logic             is_blue, is_green, in_orange, in_yellow;
	logic [ChanW-1:0] h1, s1, v1;

	function automatic wide_t sx16(input logic [15:0] x);
		return wide_t'(signed'(x));
	endfunction

	function automatic wide_t zx8(input logic [ChanW-1:0] x);
		return wide_t'({10'd0, x});
	endfunction

	function automatic logic win_hit(input window_t w, input logic [ChanW-1:0] h,
			input logic [ChanW-1:0] s, input logic [ChanW-1:0] v);
		return (h >= w.min_hue) && (h <= w.max_hue) && (s >= w.min_sat) && (v >= w.min_val);
	endfunction

	assign blue_hue   = cfg.label_hues[7:0];
	assign green_hue  = cfg.label_hues[15:8];
	assign orange_hue = cfg.label_hues[23:16];
	assign yellow_hue = cfg.label_hues[31:24];
	assign misc_hue   = cfg.label_hues[39:32];

	assign wht_max_sat = cfg.white_black_limits[7:0];
	assign wht_min_val = cfg.white_black_limits[15:8];
	assign blk_max_val = cfg.white_black_limits[23:16];

	assign r_sw = cfg.frame_settings[16] ? pix.blue_in : pix.red_in;
	assign b_sw = cfg.frame_settings[16] ? pix.red_in : pix.blue_in;

	assign offset = (signed'(cfg.frame_settings[15:0]) < signed'(cfg.tilt_rule[15:0]))
		? sx16(cfg.tilt_rule[31:16]) : '0;

	assign d_br = zx8(b_sw) - zx8(r_sw);
	assign d_bg = zx8(b_sw) - zx8(pix.green_in);
	assign d_gr = zx8(pix.green_in) - zx8(r_sw);
	assign d_gb = zx8(pix.green_in) - zx8(b_sw);

	assign thr_br = sx16(cfg.blue_diff_limits[15:0]);
	assign thr_bg = sx16(cfg.blue_diff_limits[31:16]);
	assign thr_gr = sx16(cfg.green_diff_limits[15:0]) - offset;
	assign thr_gb = sx16(cfg.green_diff_limits[31:16]) - offset;

	assign is_blue  = (d_br > thr_br) && (d_bg > thr_bg);
	assign is_green = (d_gr > thr_gr) && (d_gb > thr_gb);

	// RGB stage result
	always_comb begin
		if (is_blue) begin
			h1 = blue_hue;
			s1 = FullLevel;
			v1 = FullLevel;
		end else if (is_green) begin
			h1 = green_hue;
			s1 = FullLevel;
			v1 = FullLevel;
		end else begin
			h1 = pix.hue_in;
			s1 = pix.sat_in;
			v1 = pix.val_in;
		end
	end

	assign in_orange = win_hit(cfg.orange_window, h1, s1, v1);
	assign in_yellow = win_hit(cfg.yellow_window, h1, s1, v1);

	// HSV priority chain
	always_comb begin
		res.hue_out = h1;
		res.sat_out = s1;
		res.val_out = v1;
		if (h1 == blue_hue) begin
			// kept as is
		end else if (h1 == green_hue) begin
			if (s1 != FullLevel || v1 != FullLevel) begin
				res.hue_out = misc_hue;
				res.sat_out = FullLevel;
				res.val_out = FullLevel;
			end
		end else if (in_orange) begin
			res.hue_out = orange_hue;
			res.sat_out = FullLevel;
			res.val_out = FullLevel;
		end else if (in_yellow) begin
			res.hue_out = yellow_hue;
			res.sat_out = FullLevel;
			res.val_out = FullLevel;
		end else if (v1 <= blk_max_val) begin
			res.sat_out = ZeroLevel;
			res.val_out = ZeroLevel;
		end else if (s1 < wht_max_sat && v1 >= wht_min_val) begin
			res.sat_out = ZeroLevel;
			res.val_out = FullLevel;
		end
	end

endmodule

FILE: rtl/core/color_class_pixel_segmenter_top.sv
`timescale 1ns / 1ps
// Flow: a transferred pixel passes the input register, the classifier logic and then
//   the result register, which shows it with done high.
// Throughput: one pixel per clock; input register, classifier logic, result register.
// busy is held low: the block always takes start, and the receiver cannot stall.
// Reset (arst_n low, asynchronous): pipeline valids and all settings registers clear.
module color_class_pixel_segmenter_top
	import ccps_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	// pixel command channel
	input  logic                start,
	output logic                busy,
	input  pix_in_t             pixel,
	// result channel, one-cycle strobe
	output logic                done,
	output pix_out_t            result,
	// settings write port
	input  logic                wr_en,
	input  logic [CfgIdxW-1:0]  wr_index,
	input  logic [CfgDataW-1:0] wr_data
);

	cfg_t     cfg_q;
	pix_in_t  pix_s1;
	logic     vld_s1;
	pix_out_t res_comb;
	pix_out_t res_s2;
	logic     vld_s2;

	// Never refuses a transfer: each stage moves every cycle.
	assign busy = 1'b0;

	// Settings registers. Software must write these only while the pipe is empty; the block does not enforce it.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (wr_en) begin
			unique case (reg_idx_t'(wr_index))
				REG_ORANGE_WINDOW:  cfg_q.orange_window      <= window_t'(wr_data[31:0]);
				REG_YELLOW_WINDOW:  cfg_q.yellow_window      <= window_t'(wr_data[31:0]);
				REG_GREEN_DIFF:     cfg_q.green_diff_limits  <= wr_data[31:0];
				REG_BLUE_DIFF:      cfg_q.blue_diff_limits   <= wr_data[31:0];
				REG_WHITE_BLACK:    cfg_q.white_black_limits <= wr_data[23:0];
				REG_LABEL_HUES:     cfg_q.label_hues         <= wr_data[39:0];
				REG_TILT_RULE:      cfg_q.tilt_rule          <= wr_data[31:0];
				REG_FRAME_SETTINGS: cfg_q.frame_settings     <= wr_data[16:0];
				default: ;
			endcase
		end
	end

	// Stage 1: capture the pixel on a transfer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else begin
			vld_s1 <= start && !busy;
		end
	end

	always_ff @(posedge clk) begin
		if (start && !busy) begin
			pix_s1 <= pixel;
		end
	end

	// RGB threshold test followed by the HSV priority chain.
	ccps_classify u_classify (
		.cfg (cfg_q),
		.pix (pix_s1),
		.res (res_comb)
	);

	// Stage 2: result register, strobed out for one cycle.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
		end else begin
			vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (vld_s1) begin
			res_s2 <= res_comb;
		end
	end

	assign done   = vld_s2;
	assign result = res_s2;

endmodule

FILE: rtl/core/ccps_checker.sv
`timescale 1ns / 1ps

module ccps_checker
	import ccps_pkg::*;
(
	input logic     clk,
	input logic     arst_n,
	input logic     start,
	input logic     busy,
	input pix_in_t  pixel,
	input logic     done,
	input pix_out_t result
);

	// every transfer yields a result, through the input and result registers
	a_result_follows: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |-> ##2 done)
		else $error("missing result after pixel transfer");

	// no result without an earlier transfer
	a_no_spurious: assert property (@(posedge clk) disable iff (!arst_n)
		!(start && !busy) |-> ##2 !done)
		else $error("result without pixel transfer");

	// full-rate stream: the block never pushes back
	a_never_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start |-> !busy)
		else $error("start refused");

	// a transferred pixel carries known bits
	a_pixel_known: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |-> !$isunknown(pixel))
		else $error("unknown bits in pixel transfer");

	// a strobed result carries known bits
	a_result_known: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !$isunknown(result))
		else $error("unknown bits in result");

endmodule

bind color_class_pixel_segmenter_top ccps_checker u_ccps_checker (
	.clk    (clk),
	.arst_n (arst_n),
	.start  (start),
	.busy   (busy),
	.pixel  (pixel),
	.done   (done),
	.result (result)
);

FILE: test/tb_color_class_pixel_segmenter_top.sv
`timescale 1ns / 1ps

module tb_color_class_pixel_segmenter_top
	import ccps_pkg::*;
;

	// ------------------------------------------------------------------
	// Expected-label store and label predictor.
	// A pixel is noted at its start transfer, and a result is checked at
	// its done strobe against the oldest pending label.
	// ------------------------------------------------------------------
	class label_scoreboard;
		cfg_t     cfg;
		pix_out_t expected_labels[$];
		int       errors;
		int       pixels;
		int       results;

		function new();
			cfg = '0;
		endfunction

		function void set_reg(reg_idx_t idx, logic [CfgDataW-1:0] d);
			case (idx)
				REG_ORANGE_WINDOW:  cfg.orange_window = window_t'(d[31:0]);
				REG_YELLOW_WINDOW:  cfg.yellow_window = window_t'(d[31:0]);
				REG_GREEN_DIFF:     cfg.green_diff_limits = d[31:0];
				REG_BLUE_DIFF:      cfg.blue_diff_limits = d[31:0];
				REG_WHITE_BLACK:    cfg.white_black_limits = d[23:0];
				REG_LABEL_HUES:     cfg.label_hues = d[39:0];
				REG_TILT_RULE:      cfg.tilt_rule = d[31:0];
				REG_FRAME_SETTINGS: cfg.frame_settings = d[16:0];
				default: ;
			endcase
		endfunction

		function int s16(logic [15:0] x);
			return int'($signed(x));
		endfunction

		function bit in_window(window_t w, logic [7:0] h, logic [7:0] s, logic [7:0] v);
			return h >= w.min_hue && h <= w.max_hue && s >= w.min_sat && v >= w.min_val;
		endfunction

		function pix_out_t classify_pixel(pix_in_t p);
			int         r, g, b, t, offset;
			logic [7:0] h, s, v;
			logic [7:0] lab_blue, lab_green, lab_orange, lab_yellow, lab_other;
			pix_out_t   o;
			r = p.red_in;
			g = p.green_in;
			b = p.blue_in;
			h = p.hue_in;
			s = p.sat_in;
			v = p.val_in;
			lab_blue   = cfg.label_hues[7:0];
			lab_green  = cfg.label_hues[15:8];
			lab_orange = cfg.label_hues[23:16];
			lab_yellow = cfg.label_hues[31:24];
			lab_other  = cfg.label_hues[39:32];
			offset = 0;
			if (s16(cfg.frame_settings[15:0]) < s16(cfg.tilt_rule[15:0]))
				offset = s16(cfg.tilt_rule[31:16]);
			if (cfg.frame_settings[16]) begin
				t = r;
				r = b;
				b = t;
			end
			// RGB stage, exact signed math
			if (b - r > s16(cfg.blue_diff_limits[15:0]) &&
			    b - g > s16(cfg.blue_diff_limits[31:16])) begin
				h = lab_blue;
				s = FullLevel;
				v = FullLevel;
			end else if (g - r > s16(cfg.green_diff_limits[15:0]) - offset &&
			             g - b > s16(cfg.green_diff_limits[31:16]) - offset) begin
				h = lab_green;
				s = FullLevel;
				v = FullLevel;
			end
			// HSV chain; blue hue is kept untouched
			if (h != lab_blue) begin
				if (h == lab_green) begin
					if (s != FullLevel || v != FullLevel) begin
						h = lab_other;
						s = FullLevel;
						v = FullLevel;
					end
				end else if (in_window(cfg.orange_window, h, s, v)) begin
					h = lab_orange;
					s = FullLevel;
					v = FullLevel;
				end else if (in_window(cfg.yellow_window, h, s, v)) begin
					h = lab_yellow;
					s = FullLevel;
					v = FullLevel;
				end else if (v <= cfg.white_black_limits[23:16]) begin
					s = ZeroLevel;
					v = ZeroLevel;
				end else if (s < cfg.white_black_limits[7:0] &&
				             v >= cfg.white_black_limits[15:8]) begin
					s = ZeroLevel;
					v = FullLevel;
				end
			end
			o.hue_out = h;
			o.sat_out = s;
			o.val_out = v;
			return o;
		endfunction

		function void note_pixel(pix_in_t p);
			expected_labels.push_back(classify_pixel(p));
			pixels++;
		endfunction

		task report(string what, int exp_v, int got_v);
			$display("%0t ns mismatch on %s: expected %0d, got %0d", $time, what, exp_v, got_v);
			errors++;
		endtask

		task check_result(pix_out_t got);
			pix_out_t exp;
			results++;
			if (expected_labels.size() == 0) begin
				report("result with no pixel pending", -1, int'(got));
			end else begin
				exp = expected_labels.pop_front();
				if (got.hue_out !== exp.hue_out)
					report("hue_out", exp.hue_out, got.hue_out);
				if (got.sat_out !== exp.sat_out)
					report("sat_out", exp.sat_out, got.sat_out);
				if (got.val_out !== exp.val_out)
					report("val_out", exp.val_out, got.val_out);
			end
		endtask

		task check_drained();
			if (expected_labels.size() != 0)
				report("results still owed at end", 0, expected_labels.size());
		endtask
	endclass

	// ------------------------------------------------------------------
	// Clock, reset and DUT hookup
	// ------------------------------------------------------------------
	logic                clk = 1'b0;
	logic                arst_n;
	logic                start;
	logic                busy;
	pix_in_t             pixel;
	logic                done;
	pix_out_t            result;
	logic                wr_en;
	logic [CfgIdxW-1:0]  wr_index;
	logic [CfgDataW-1:0] wr_data;

	// shadow of the values loaded into the settings registers, by index
	logic [CfgDataW-1:0] setting [8];
	label_scoreboard     sb = new();
	int                  phases;

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	color_class_pixel_segmenter_top DUT (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (start),
		.busy     (busy),
		.pixel    (pixel),
		.done     (done),
		.result   (result),
		.wr_en    (wr_en),
		.wr_index (wr_index),
		.wr_data  (wr_data)
	);

	// Monitor: signals are read before this edge's updates land, so both
	// the start transfer and the done strobe are seen race-free.
	always @(posedge clk) begin
		if (arst_n) begin
			if (start && !busy)
				sb.note_pixel(pixel);
			if (done)
				sb.check_result(result);
		end
	end

	// ------------------------------------------------------------------
	// Drivers
	// ------------------------------------------------------------------

	// Present one pixel after an idle gap, if any, and hold it until the transfer.
	// start is only lowered when a gap follows, never in the step it is raised.
	task automatic send_pixel(input pix_in_t p, input int gap);
		bit took;
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		start <= 1'b1;
		pixel <= p;
		do begin
			@(negedge clk);
			took = !busy;
			@(posedge clk);
		end while (!took);
	endtask

	task automatic send_list(input pix_in_t list[$]);
		foreach (list[i])
			send_pixel(list[i], $urandom_range(0, 14));
	endtask

	// Stop feeding and let every owed result come back, first letting the monitor
	// log the last transfer.
	task automatic wait_drained();
		start <= 1'b0;
		@(posedge clk);
		while (sb.expected_labels.size() != 0)
			@(posedge clk);
		repeat (3) @(posedge clk);
	endtask

	// Write all eight registers back to back; block is idle here.
	task automatic load_settings();
		for (int k = 0; k < 8; k++) begin
			wr_en    <= 1'b1;
			wr_index <= CfgIdxW'(k);
			wr_data  <= setting[k];
			sb.set_reg(reg_idx_t'(k), setting[k]);
			@(posedge clk);
		end
		wr_en <= 1'b0;
	endtask

	// small signed threshold, with the 16-bit extremes now and then
	function automatic logic [15:0] pick_s16();
		case ($urandom_range(0, 9))
			0: return 16'h8000;
			1: return 16'h7FFF;
			default: return 16'($urandom_range(0, 160)) - 16'd80;
		endcase
	endfunction

	function automatic window_t pick_window();
		window_t w;
		w.min_hue = 8'($urandom_range(0, 230));
		// now and then a random max hue, which can give an empty window (min above max)
		w.max_hue = ($urandom_range(0, 5) == 0) ? 8'($urandom) :
			w.min_hue + 8'($urandom_range(0, 25));
		w.min_sat = 8'($urandom_range(0, 220));
		w.min_val = 8'($urandom_range(0, 220));
		return w;
	endfunction

	// style 0: all zero, 1: all ones, 2: plausible tuning, 3: raw random
	task automatic pick_settings(input int style);
		for (int k = 0; k < 8; k++) begin
			case (style)
				0: setting[k] = '0;
				1: setting[k] = '1;
				3: setting[k] = {8'($urandom), 32'($urandom)};
				default: ;
			endcase
		end
		if (style == 2) begin
			setting[REG_ORANGE_WINDOW]  = 40'(pick_window());
			setting[REG_YELLOW_WINDOW]  = 40'(pick_window());
			setting[REG_GREEN_DIFF]     = {8'h00, pick_s16(), pick_s16()};
			setting[REG_BLUE_DIFF]      = {8'h00, pick_s16(), pick_s16()};
			setting[REG_WHITE_BLACK]    = {16'h0000, 8'($urandom_range(0, 60)),
				8'($urandom_range(150, 255)), 8'($urandom_range(0, 80))};
			setting[REG_LABEL_HUES]     = {8'($urandom), 8'($urandom), 8'($urandom),
				8'($urandom), 8'($urandom)};
			// sometimes blue and green share a label hue
			if ($urandom_range(0, 4) == 0)
				setting[REG_LABEL_HUES][15:8] = setting[REG_LABEL_HUES][7:0];
			setting[REG_TILT_RULE]      = {8'h00, pick_s16(), pick_s16()};
			setting[REG_FRAME_SETTINGS] = {23'd0, 1'($urandom), pick_s16()};
		end
	endtask

	// Random pixel, mostly steered at the current labels, windows and limits
	// so every rung of the priority chain gets hit.
	function automatic pix_in_t make_pixel();
		pix_in_t p;
		window_t w;
		int      k;
		p = {32'($urandom), 16'($urandom)};
		case ($urandom_range(0, 9))
			3: begin
				k = $urandom_range(0, 4);
				p.hue_in = sb.cfg.label_hues[8*k +: 8];
				if ($urandom_range(0, 1)) begin
					p.sat_in = FullLevel;
					p.val_in = FullLevel;
				end
			end
			4, 5: begin
				w = $urandom_range(0, 1) ? sb.cfg.orange_window : sb.cfg.yellow_window;
				if (w.min_hue <= w.max_hue)
					p.hue_in = 8'($urandom_range(w.min_hue, w.max_hue));
				p.sat_in = 8'($urandom_range(w.min_sat, 255));
				p.val_in = 8'($urandom_range(w.min_val, 255));
			end
			6: p.val_in = 8'($urandom_range(0, sb.cfg.white_black_limits[23:16]));
			7: begin
				p.sat_in = 8'($urandom_range(0, sb.cfg.white_black_limits[7:0]));
				p.val_in = 8'($urandom_range(sb.cfg.white_black_limits[15:8], 255));
			end
			8: begin
				p.blue_in  = 8'($urandom_range(140, 255));
				p.red_in   = 8'($urandom_range(0, 130));
				p.green_in = 8'($urandom_range(0, 130));
			end
			9: begin
				// near-equal channels sit on the diff thresholds
				p.green_in = 8'($urandom_range(0, 255));
				p.red_in   = p.green_in - 8'($urandom_range(0, 40));
				p.blue_in  = p.green_in - 8'($urandom_range(0, 40));
			end
			default: ;
		endcase
		return p;
	endfunction

	// ------------------------------------------------------------------
	// Main sequence
	// ------------------------------------------------------------------
	initial begin : main
		pix_in_t list[$];
		int      style;
		bit      no_gaps;

		arst_n   <= 1'b0;
		start    <= 1'b0;
		pixel    <= '0;
		wr_en    <= 1'b0;
		wr_index <= '0;
		wr_data  <= '0;
		phases   = 0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Settings straight out of reset (all zero)
		list = '{
			pix_in_t'{8'd0, 8'd0, 8'd255, 8'd7, 8'd7, 8'd7},
			pix_in_t'{8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255},
			pix_in_t'{8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0}
		};
		send_list(list);
		wait_drained();

		// Hand-tuned settings: orange 5..20, yellow 25..40, diff limits 30,
		// tilt below its limit so green limits drop by 20.
		setting[REG_ORANGE_WINDOW]  = 40'h00_6464_1405;
		setting[REG_YELLOW_WINDOW]  = 40'h00_6464_2819;
		setting[REG_GREEN_DIFF]     = 40'h00_001E_001E;
		setting[REG_BLUE_DIFF]      = 40'h00_001E_001E;
		setting[REG_WHITE_BLACK]    = 40'h00_001E_C828;
		setting[REG_LABEL_HUES]     = 40'hC8_1E_0A_3C_78;
		setting[REG_TILT_RULE]      = 40'h00_0014_0000;
		setting[REG_FRAME_SETTINGS] = 40'h00_0000_FFFB;
		load_settings();
		phases++;
		list = '{
			pix_in_t'{8'd0, 8'd0, 8'd255, 8'd0, 8'd0, 8'd0},         // blue by RGB
			pix_in_t'{8'd0, 8'd255, 8'd0, 8'd0, 8'd0, 8'd0},         // green by RGB
			pix_in_t'{8'd100, 8'd112, 8'd100, 8'd90, 8'd50, 8'd150}, // green only via tilt
			pix_in_t'{8'd100, 8'd110, 8'd100, 8'd90, 8'd50, 8'd150}, // green diff on limit
			pix_in_t'{8'd100, 8'd100, 8'd130, 8'd90, 8'd50, 8'd150}, // blue diff on limit
			pix_in_t'{8'd50, 8'd50, 8'd50, 8'd10, 8'd200, 8'd200},   // orange
			pix_in_t'{8'd50, 8'd50, 8'd50, 8'd5, 8'd100, 8'd100},    // orange low corner
			pix_in_t'{8'd50, 8'd50, 8'd50, 8'd20, 8'd99, 8'd100},    // sat just short
			pix_in_t'{8'd50, 8'd50, 8'd50, 8'd40, 8'd255, 8'd255},   // yellow top hue
			pix_in_t'{8'd50, 8'd50, 8'd50, 8'd90, 8'd200, 8'd30},    // black
			pix_in_t'{8'd50, 8'd50, 8'd50, 8'd90, 8'd39, 8'd200},    // white
			pix_in_t'{8'd50, 8'd50, 8'd50, 8'd60, 8'd200, 8'd255},   // green re-check
			pix_in_t'{8'd50, 8'd50, 8'd50, 8'd60, 8'd255, 8'd255},   // green kept
			pix_in_t'{8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255}
		};
		send_list(list);
		wait_drained();

		// Red/blue swapped, tilt equal to its limit (no offset), blue and
		// green labels equal, orange window empty.
		setting[REG_ORANGE_WINDOW]  = 40'h00_0000_0514;
		setting[REG_LABEL_HUES]     = 40'hC8_1E_0A_50_50;
		setting[REG_FRAME_SETTINGS] = 40'h00_0001_0000;
		load_settings();
		phases++;
		list = '{
			pix_in_t'{8'd255, 8'd0, 8'd0, 8'd3, 8'd3, 8'd3},
			pix_in_t'{8'd0, 8'd0, 8'd255, 8'd10, 8'd200, 8'd200},
			pix_in_t'{8'd100, 8'd112, 8'd100, 8'd90, 8'd50, 8'd150},
			pix_in_t'{8'd50, 8'd50, 8'd50, 8'd80, 8'd0, 8'd0},
			pix_in_t'{8'd50, 8'd50, 8'd50, 8'd10, 8'd255, 8'd255},
			pix_in_t'{8'd0, 8'd255, 8'd0, 8'd30, 8'd100, 8'd100}
		};
		send_list(list);
		wait_drained();

		// Random phases: first all-zero and all-ones settings, then mostly
		// plausible tuning with some raw random words. Some phases run
		// back to back with no idle cycles at all.
		for (int ph = 0; ph < 11; ph++) begin
			style = (ph < 2) ? ph : (($urandom_range(0, 3) == 0) ? 3 : 2);
			pick_settings(style);
			load_settings();
			phases++;
			no_gaps = ($urandom_range(0, 3) == 0);
			for (int n = 0; n < 50; n++)
				send_pixel(make_pixel(), no_gaps ? 0 : $urandom_range(0, 14));
			wait_drained();
		end

		sb.check_drained();
		$display("Ran %0d pixels under %0d register settings; %0d results compared.",
			sb.pixels, phases, sb.results);
		if (sb.errors == 0) begin
			$display("TB_OK");
		end else begin
			$display("TB_ERROR");
		end
		$finish;
	end

	// Hang guard, far beyond the slowest legal run.
	initial begin
		#5ms;
		$display("TB_ERROR");
		$finish;
	end

endmodule

FILE: files.f
rtl/core/ccps_pkg.sv
rtl/core/ccps_classify.sv
rtl/core/color_class_pixel_segmenter_top.sv
rtl/core/ccps_checker.sv
test/tb_color_class_pixel_segmenter_top.sv
